// ----- design/tpqs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the two-level preemptive scheduler.
// Depends on nothing; tpqs_fifo and the top level use it by scoped names.
package tpqs_pkg;

  localparam int NUM_PROCS  = 64;
  localparam int BURST_BITS = 16;
  localparam int ID_W       = 6;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int PTR_W      = $clog2(NUM_PROCS);
  localparam int CNT_W      = $clog2(NUM_PROCS + 1);
  localparam int ENTRY_W    = ID_W + BURST_BITS;

  // Request kinds
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Process classes
  localparam logic CLASS_SYSTEM = 1'b0;
  localparam logic CLASS_USER   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ID_BUSY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_BURST = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE_TICK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RAN       = 3'd4;

  // One queued process: its id and the service time it still needs
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [BURST_BITS-1:0] rem;
  } fifo_entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    fifo_entry_t wdata;
  } fifo_ctl_t;

  typedef struct packed {
    logic        nonempty;
    fifo_entry_t head;
  } fifo_stat_t;

  // Circular pointer advance
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(NUM_PROCS - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- design/tpqs_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tpqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/tpqs_fifo.sv -----
`timescale 1ns / 1ps
// Circular FIFO of queued processes: pointers and count around one RAM.
// Depends on tpqs_pkg and tpqs_ram.
module tpqs_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tpqs_pkg::fifo_ctl_t   ctl,
  output tpqs_pkg::fifo_stat_t  stat
);

  logic [tpqs_pkg::PTR_W-1:0]   head_r, head_nxt;
  logic [tpqs_pkg::PTR_W-1:0]   tail_r, tail_nxt;
  logic [tpqs_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [tpqs_pkg::ENTRY_W-1:0] head_word;

  // Head is read every cycle; the read is registered, so data is valid in the cycle after the pointer settles
  tpqs_ram #(
    .WIDTH(tpqs_pkg::ENTRY_W),
    .DEPTH(tpqs_pkg::NUM_PROCS)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.push),
    .waddr(tail_r),
    .wdata(ctl.wdata),
    .raddr(head_r),
    .rdata(head_word)
  );

  always_comb begin
    head_nxt  = ctl.pop  ? tpqs_pkg::ptr_inc(head_r) : head_r;
    tail_nxt  = ctl.push ? tpqs_pkg::ptr_inc(tail_r) : tail_r;
    count_nxt = count_r;
    case ({ctl.push, ctl.pop})
      2'b10:   count_nxt = count_r + tpqs_pkg::CNT_W'(1);
      2'b01:   count_nxt = count_r - tpqs_pkg::CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign stat.nonempty = (count_r != '0);
  assign stat.head     = tpqs_pkg::fifo_entry_t'(head_word);

endmodule

// ----- design/two_level_preemptive_queue_scheduler_top.sv -----
`timescale 1ns / 1ps
// Top level of the two-level preemptive scheduler: request decode, dispatch.
// Depends on tpqs_pkg and tpqs_fifo (two instances, system and user class).

// A request beat is taken at a rising edge with start high and busy low. Busy
// then stays high for exactly one cycle while the FIFO heads, read from RAM
// during that cycle, are combined with the running process and written back;
// so the block cannot take a new request while busy is high. The result beat
// appears on the out_ ports for one cycle, flagged by out_valid, in the cycle
// after the write-back edge. The receiver cannot stall: sample out_ whenever
// out_valid is high. Every request yields exactly one result beat. Arrivals
// for a given time must be issued before that time's tick. No clearing pass
// after reset.
module two_level_preemptive_queue_scheduler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_req_type,
  input  logic [tpqs_pkg::ID_W-1:0]       in_proc_id,
  input  logic                            in_proc_class,
  input  logic [15:0]                     in_burst,
  output logic                            out_valid,
  output logic [tpqs_pkg::STATUS_W-1:0]   out_status,
  output logic [tpqs_pkg::ID_W-1:0]       out_run_id,
  output logic                            out_finished,
  output logic [tpqs_pkg::TIME_W-1:0]     out_finish_time
);

  // Request capture
  logic                             busy_r;
  logic                             req_type_r;
  logic [tpqs_pkg::ID_W-1:0]        req_id_r;
  logic                             req_class_r;
  logic [tpqs_pkg::BURST_BITS-1:0]  req_burst_r;

  // Scheduler state: the running process lives in registers, not in a FIFO
  logic [tpqs_pkg::NUM_PROCS-1:0]   id_active_r, id_active_nxt;
  logic                             run_valid_r, run_valid_nxt;
  logic [tpqs_pkg::ID_W-1:0]        run_id_r, run_id_nxt;
  logic                             run_class_r, run_class_nxt;
  logic [tpqs_pkg::BURST_BITS-1:0]  run_rem_r, run_rem_nxt;
  logic [tpqs_pkg::TIME_W-1:0]      time_r, time_nxt;

  // Result register
  logic                             out_valid_r;
  logic [tpqs_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [tpqs_pkg::ID_W-1:0]        out_run_id_r, out_run_id_nxt;
  logic                             out_finished_r, out_finished_nxt;
  logic [tpqs_pkg::TIME_W-1:0]      out_finish_time_r, out_finish_time_nxt;

  tpqs_pkg::fifo_ctl_t  sys_ctl, usr_ctl;
  tpqs_pkg::fifo_stat_t sys_stat, usr_stat;

  logic                             take;
  logic                             preempt;
  logic                             keep_running;
  logic                             sel_valid;
  logic [tpqs_pkg::ID_W-1:0]        sel_id;
  logic                             sel_class;
  logic [tpqs_pkg::BURST_BITS-1:0]  sel_rem;
  logic [tpqs_pkg::BURST_BITS-1:0]  rem_dec;

  assign take = start && !busy_r;

  tpqs_fifo u_sys_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (sys_ctl),
    .stat (sys_stat)
  );

  tpqs_fifo u_usr_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (usr_ctl),
    .stat (usr_stat)
  );

  always_comb begin
    id_active_nxt       = id_active_r;
    run_valid_nxt       = run_valid_r;
    run_id_nxt          = run_id_r;
    run_class_nxt       = run_class_r;
    run_rem_nxt         = run_rem_r;
    time_nxt            = time_r;
    out_status_nxt      = tpqs_pkg::ST_QUEUED;
    out_run_id_nxt      = '0;
    out_finished_nxt    = 1'b0;
    out_finish_time_nxt = '0;
    sys_ctl             = '0;
    usr_ctl             = '0;

    // Tick decision terms
    preempt      = run_valid_r && (run_class_r == tpqs_pkg::CLASS_USER) &&
                   sys_stat.nonempty;
    keep_running = run_valid_r && !preempt;
    sel_valid    = 1'b0;
    sel_id       = run_id_r;
    sel_class    = run_class_r;
    sel_rem      = run_rem_r;
    if (keep_running) begin
      sel_valid = 1'b1;
    end else if (sys_stat.nonempty) begin
      sel_valid = 1'b1;
      sel_id    = sys_stat.head.id;
      sel_class = tpqs_pkg::CLASS_SYSTEM;
      sel_rem   = sys_stat.head.rem;
    end else if (usr_stat.nonempty) begin
      sel_valid = 1'b1;
      sel_id    = usr_stat.head.id;
      sel_class = tpqs_pkg::CLASS_USER;
      sel_rem   = usr_stat.head.rem;
    end
    rem_dec = sel_rem - tpqs_pkg::BURST_BITS'(1);

    if (busy_r) begin
      if (req_type_r == tpqs_pkg::REQ_ARRIVAL) begin
        if ((32'(req_id_r) >= tpqs_pkg::NUM_PROCS) || id_active_r[req_id_r]) begin
          out_status_nxt = tpqs_pkg::ST_ID_BUSY;
        end else if (req_burst_r == '0) begin
          out_status_nxt = tpqs_pkg::ST_ZERO_BURST;
        end else begin
          // Queue at the tail of its class
          out_status_nxt          = tpqs_pkg::ST_QUEUED;
          id_active_nxt[req_id_r] = 1'b1;
          if (req_class_r == tpqs_pkg::CLASS_USER) begin
            usr_ctl.push  = 1'b1;
            usr_ctl.wdata = '{id: req_id_r, rem: req_burst_r};
          end else begin
            sys_ctl.push  = 1'b1;
            sys_ctl.wdata = '{id: req_id_r, rem: req_burst_r};
          end
        end
      end else begin
        time_nxt = time_r + tpqs_pkg::TIME_W'(1);
        // Send a preempted user process back to the user tail
        if (preempt) begin
          usr_ctl.push  = 1'b1;
          usr_ctl.wdata = '{id: run_id_r, rem: run_rem_r};
        end
        if (!keep_running) begin
          sys_ctl.pop = sys_stat.nonempty;
          usr_ctl.pop = !sys_stat.nonempty && usr_stat.nonempty;
        end
        if (!sel_valid) begin
          out_status_nxt = tpqs_pkg::ST_IDLE_TICK;
          run_valid_nxt  = 1'b0;
        end else begin
          out_status_nxt = tpqs_pkg::ST_RAN;
          out_run_id_nxt = sel_id;
          run_id_nxt     = sel_id;
          run_class_nxt  = sel_class;
          run_rem_nxt    = rem_dec;
          if (rem_dec == '0) begin
            out_finished_nxt      = 1'b1;
            out_finish_time_nxt   = time_nxt;
            id_active_nxt[sel_id] = 1'b0;
            run_valid_nxt         = 1'b0;
          end else begin
            run_valid_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      id_active_r <= '0;
      run_valid_r <= 1'b0;
      time_r      <= '0;
    end else begin
      busy_r      <= take;
      out_valid_r <= busy_r;
      id_active_r <= id_active_nxt;
      run_valid_r <= run_valid_nxt;
      time_r      <= time_nxt;
    end
  end

  // Payload registers: hold request fields, advance running-process and result fields
  always_ff @(posedge clk) begin
    if (take) begin
      req_type_r  <= in_req_type;
      req_id_r    <= in_proc_id;
      req_class_r <= in_proc_class;
      req_burst_r <= in_burst[tpqs_pkg::BURST_BITS-1:0];
    end
    run_id_r          <= run_id_nxt;
    run_class_r       <= run_class_nxt;
    run_rem_r         <= run_rem_nxt;
    out_status_r      <= out_status_nxt;
    out_run_id_r      <= out_run_id_nxt;
    out_finished_r    <= out_finished_nxt;
    out_finish_time_r <= out_finish_time_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_run_id      = out_run_id_r;
  assign out_finished    = out_finished_r;
  assign out_finish_time = out_finish_time_r;

endmodule
